/* sv/dmpi_pkg.sv */
// ----------------------------------------------------------------------------
// dmpi_pkg
// Shared widths, codes, command table and controller/datapath types of the
// dual-motor PI speed controller.
// ----------------------------------------------------------------------------
package dmpi_pkg;

    // default number of capture period bits in use
    localparam int CAPTURE_BITS_DEF = 16;

    // field and state widths
    localparam int OP_W      = 2;
    localparam int PERIOD_W  = 16;
    localparam int CHAR_W    = 8;
    localparam int PINS_W    = 4;
    localparam int DUTY_W    = 16;
    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 20;
    localparam int SUM_W     = 32;
    localparam int ERR_W     = 31;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    // divider unit: dividend and divisor widths
    localparam int DIV_W = 30;
    localparam int DVS_W = 16;

    // products and their sum
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int ACC_W    = PROD_I_W + 1;

    // item opcodes
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // frame terminator and error scale
    localparam logic [CHAR_W-1:0] FRAME_END = 8'h23;
    localparam logic [13:0]       ERR_SCALE = 14'd10000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INT_TWO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 3'd6;

    // register reset values
    localparam logic [SPEED_W-1:0] RST_TARGET     = 16'd100;
    localparam logic [SPEED_W-1:0] RST_SCALE      = 16'd3000;
    localparam logic [GAIN_W-1:0]  RST_PROP_ONE   = 20'd22938;
    localparam logic [GAIN_W-1:0]  RST_INT_ONE    = 20'd2621;
    localparam logic [GAIN_W-1:0]  RST_PROP_TWO   = 20'd19661;
    localparam logic [GAIN_W-1:0]  RST_INT_TWO    = 20'd1966;
    localparam logic [DUTY_W-1:0]  RST_DUTY_LIMIT = 16'd20000;

    // motion command characters
    localparam logic [CHAR_W-1:0] CMD_STOP  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CMD_B     = 8'h42;
    localparam logic [CHAR_W-1:0] CMD_C     = 8'h43;
    localparam logic [CHAR_W-1:0] CMD_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CMD_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CMD_W     = 8'h57;
    localparam logic [CHAR_W-1:0] CMD_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CMD_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CMD_N     = 8'h4E;

    // action of one command byte
    typedef struct packed {
        logic              known;
        logic [PINS_W-1:0] pins;
        logic              clr_one;
        logic              clr_two;
    } t_cmd_act;

    function automatic t_cmd_act decode_command(input logic [CHAR_W-1:0] c);
        t_cmd_act a;
        a = '0;
        a.known = 1'b1;
        case (c)
            CMD_STOP: begin
                a.pins = 4'h0; a.clr_one = 1'b1; a.clr_two = 1'b1;
            end
            CMD_B: begin
                a.pins = 4'h1; a.clr_two = 1'b1;
            end
            CMD_C: begin
                a.pins = 4'h2; a.clr_two = 1'b1;
            end
            CMD_A: begin
                a.pins = 4'h4; a.clr_one = 1'b1;
            end
            CMD_D: begin
                a.pins = 4'h8; a.clr_one = 1'b1;
            end
            CMD_W: a.pins = 4'hA;
            CMD_E: a.pins = 4'h5;
            CMD_S: a.pins = 4'h6;
            CMD_N: a.pins = 4'h9;
            default: a = '0;
        endcase
        return a;
    endfunction

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CAP_WAIT,
        S_NUM,
        S_ERR_START,
        S_ERR_WAIT,
        S_PROD_P,
        S_PROD_I,
        S_DUTY,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cap_start;
        logic cap_store;
        logic timeout;
        logic apply_cmd;
        logic motor;
        logic num_calc;
        logic err_start;
        logic err_store;
        logic prod_p;
        logic prod_i;
        logic duty_upd;
        logic out_load;
        logic out_written;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            frame_ok;
        logic            div_done;
    } t_dp_stat;

endpackage

/* sv/dmpi_if.sv */
// ----------------------------------------------------------------------------
// dmpi channel interfaces
// Input item, result item and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------

// input item channel
interface dmpi_in_if;
    logic                                valid;
    logic                                ready;
    logic [dmpi_pkg::OP_W-1:0]           opcode;
    logic                                motor_select;
    logic [dmpi_pkg::PERIOD_W-1:0]       capture_period;
    logic [dmpi_pkg::CHAR_W-1:0]         command_byte;
    logic [dmpi_pkg::CHAR_W-1:0]         end_byte;

    modport source (
        output valid, opcode, motor_select, capture_period, command_byte, end_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, motor_select, capture_period, command_byte, end_byte,
        output ready
    );
endinterface

// result item channel
interface dmpi_out_if;
    logic                                valid;
    logic                                ready;
    logic [dmpi_pkg::PINS_W-1:0]         direction_pins;
    logic [dmpi_pkg::DUTY_W-1:0]         duty_motor_one;
    logic [dmpi_pkg::DUTY_W-1:0]         duty_motor_two;
    logic                                duty_written;

    modport source (
        output valid, direction_pins, duty_motor_one, duty_motor_two, duty_written,
        input  ready
    );
    modport sink (
        input  valid, direction_pins, duty_motor_one, duty_motor_two, duty_written,
        output ready
    );
endinterface

// register write channel
interface dmpi_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dmpi_pkg::CFG_IDX_W-1:0]      index;
    logic [dmpi_pkg::CFG_W-1:0]          data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* sv/dmpi_div.sv */
// ----------------------------------------------------------------------------
// dmpi_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by the speed
// capture and the speed error paths.
// ----------------------------------------------------------------------------
module dmpi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dmpi_pkg::DIV_W-1:0]    i_dividend,
    input  logic [dmpi_pkg::DVS_W-1:0]    i_divisor,
    output logic [dmpi_pkg::DIV_W-1:0]    o_quotient,
    output logic                          o_done
);
    localparam int DIV_W = dmpi_pkg::DIV_W;
    localparam int DVS_W = dmpi_pkg::DVS_W;
    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   w_rem_sh;
    logic [DVS_W:0]   w_sub;
    logic             w_ge;

    // one trial subtraction per cycle
    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIV_W-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dvs});
        w_sub    = w_rem_sh - {1'b0, r_dvs};
    end

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DVS_W-1:0] : w_rem_sh[DVS_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* sv/dmpi_dp.sv */
// ----------------------------------------------------------------------------
// dmpi_dp
// Datapath: registers, item holding, speed capture, command table, speed
// error, PI products, duty saturation, integrator update and result register.
// ----------------------------------------------------------------------------
module dmpi_dp #(
    parameter int CAPTURE_BITS = dmpi_pkg::CAPTURE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register writes
    input  logic                              i_cfg_we,
    input  logic [dmpi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmpi_pkg::CFG_W-1:0]        i_cfg_data,
    // item fields
    input  logic [dmpi_pkg::OP_W-1:0]         i_opcode,
    input  logic                              i_motor_select,
    input  logic [dmpi_pkg::PERIOD_W-1:0]     i_capture_period,
    input  logic [dmpi_pkg::CHAR_W-1:0]       i_command_byte,
    input  logic [dmpi_pkg::CHAR_W-1:0]       i_end_byte,
    // control
    input  dmpi_pkg::t_dp_cmd                 i_cmd,
    output dmpi_pkg::t_dp_stat                o_stat,
    // result fields
    output logic [dmpi_pkg::PINS_W-1:0]       o_direction_pins,
    output logic [dmpi_pkg::DUTY_W-1:0]       o_duty_motor_one,
    output logic [dmpi_pkg::DUTY_W-1:0]       o_duty_motor_two,
    output logic                              o_duty_written
);
    localparam int OP_W     = dmpi_pkg::OP_W;
    localparam int PERIOD_W = dmpi_pkg::PERIOD_W;
    localparam int CHAR_W   = dmpi_pkg::CHAR_W;
    localparam int PINS_W   = dmpi_pkg::PINS_W;
    localparam int DUTY_W   = dmpi_pkg::DUTY_W;
    localparam int SPEED_W  = dmpi_pkg::SPEED_W;
    localparam int GAIN_W   = dmpi_pkg::GAIN_W;
    localparam int SUM_W    = dmpi_pkg::SUM_W;
    localparam int ERR_W    = dmpi_pkg::ERR_W;
    localparam int DIV_W    = dmpi_pkg::DIV_W;
    localparam int PROD_P_W = dmpi_pkg::PROD_P_W;
    localparam int PROD_I_W = dmpi_pkg::PROD_I_W;
    localparam int ACC_W    = dmpi_pkg::ACC_W;
    localparam int PW       = (CAPTURE_BITS < PERIOD_W) ? CAPTURE_BITS : PERIOD_W;
    localparam int SH_W     = ACC_W - 16;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // configuration registers
    logic [SPEED_W-1:0] r_target;
    logic [SPEED_W-1:0] r_scale;
    logic [GAIN_W-1:0]  r_kp_one;
    logic [GAIN_W-1:0]  r_ki_one;
    logic [GAIN_W-1:0]  r_kp_two;
    logic [GAIN_W-1:0]  r_ki_two;
    logic [DUTY_W-1:0]  r_limit;

    // held item
    logic [OP_W-1:0]     r_op;
    logic                r_sel;
    logic [PERIOD_W-1:0] r_period;
    logic [CHAR_W-1:0]   r_cmdb;
    logic [CHAR_W-1:0]   r_endb;

    // controller state
    logic [SPEED_W-1:0]      r_speed_one;
    logic [SPEED_W-1:0]      r_speed_two;
    logic signed [SUM_W-1:0] r_sum_one;
    logic signed [SUM_W-1:0] r_sum_two;
    logic [PINS_W-1:0]       r_pins;
    logic [DUTY_W-1:0]       r_duty_one;
    logic [DUTY_W-1:0]       r_duty_two;

    // working registers
    logic [DIV_W-1:0]           r_num;
    logic                       r_neg;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [PROD_P_W-1:0] r_p1;
    logic signed [PROD_I_W-1:0] r_p2;

    // result register
    logic [PINS_W-1:0] r_o_pins;
    logic [DUTY_W-1:0] r_o_d1;
    logic [DUTY_W-1:0] r_o_d2;
    logic              r_o_wr;

    logic [PERIOD_W-1:0]     w_period;
    logic [SPEED_W-1:0]      w_t_eff;
    logic [SPEED_W-1:0]      w_speed_m;
    logic signed [SUM_W-1:0] w_sum_m;
    logic [GAIN_W-1:0]       w_kp_m;
    logic [GAIN_W-1:0]       w_ki_m;
    logic signed [SPEED_W:0] w_diff;
    logic [SPEED_W-1:0]      w_mag;
    logic                    w_div_start;
    logic [DIV_W-1:0]        w_dividend;
    logic [PERIOD_W-1:0]     w_divisor;
    logic [DIV_W-1:0]        w_quo;
    logic                    w_div_done;
    logic [ERR_W-1:0]        w_qs;
    logic signed [ACC_W-1:0] w_acc;
    logic [SH_W-1:0]         w_dsh;
    logic [DUTY_W-1:0]       w_duty;
    logic signed [SUM_W:0]   w_snew;
    logic signed [SUM_W-1:0] w_sum_sat;
    dmpi_pkg::t_cmd_act      w_act;

    // capture period in use, zero read as one; zero target read as one
    always_comb begin
        w_period = PERIOD_W'(r_period[PW-1:0]);
        if (w_period == '0) begin
            w_period = PERIOD_W'(1);
        end
        w_t_eff = (r_target == '0) ? SPEED_W'(1) : r_target;
    end

    // per-motor operand selection
    always_comb begin
        w_speed_m = i_cmd.motor ? r_speed_two : r_speed_one;
        w_sum_m   = i_cmd.motor ? r_sum_two   : r_sum_one;
        w_kp_m    = i_cmd.motor ? r_kp_two    : r_kp_one;
        w_ki_m    = i_cmd.motor ? r_ki_two    : r_ki_one;
    end

    // error numerator magnitude and sign
    always_comb begin
        w_diff = $signed({1'b0, w_t_eff}) - $signed({1'b0, w_speed_m});
        w_mag  = w_diff[SPEED_W] ? SPEED_W'(-w_diff) : w_diff[SPEED_W-1:0];
    end

    // shared divider
    assign w_div_start = i_cmd.cap_start | i_cmd.err_start;
    assign w_dividend  = i_cmd.cap_start ? DIV_W'(r_scale) : r_num;
    assign w_divisor   = i_cmd.cap_start ? w_period : w_t_eff;

    dmpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // duty saturation and integrator update
    always_comb begin
        w_qs  = {1'b0, w_quo};
        w_acc = r_p1 + r_p2;
        w_dsh = w_acc[ACC_W-1:16];
        if (w_acc[ACC_W-1]) begin
            w_duty = '0;
        end else if (w_dsh > SH_W'(r_limit)) begin
            w_duty = r_limit;
        end else begin
            w_duty = w_dsh[DUTY_W-1:0];
        end
        w_snew = {w_sum_m[SUM_W-1], w_sum_m}
               + {{(SUM_W+1-ERR_W){r_err[ERR_W-1]}}, r_err};
        if (w_snew[SUM_W] != w_snew[SUM_W-1]) begin
            w_sum_sat = w_snew[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sum_sat = w_snew[SUM_W-1:0];
        end
        w_act = dmpi_pkg::decode_command(r_cmdb);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= dmpi_pkg::RST_TARGET;
            r_scale  <= dmpi_pkg::RST_SCALE;
            r_kp_one <= dmpi_pkg::RST_PROP_ONE;
            r_ki_one <= dmpi_pkg::RST_INT_ONE;
            r_kp_two <= dmpi_pkg::RST_PROP_TWO;
            r_ki_two <= dmpi_pkg::RST_INT_TWO;
            r_limit  <= dmpi_pkg::RST_DUTY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dmpi_pkg::REG_TARGET:     r_target <= i_cfg_data[SPEED_W-1:0];
                dmpi_pkg::REG_SCALE:      r_scale  <= i_cfg_data[SPEED_W-1:0];
                dmpi_pkg::REG_PROP_ONE:   r_kp_one <= i_cfg_data[GAIN_W-1:0];
                dmpi_pkg::REG_INT_ONE:    r_ki_one <= i_cfg_data[GAIN_W-1:0];
                dmpi_pkg::REG_PROP_TWO:   r_kp_two <= i_cfg_data[GAIN_W-1:0];
                dmpi_pkg::REG_INT_TWO:    r_ki_two <= i_cfg_data[GAIN_W-1:0];
                dmpi_pkg::REG_DUTY_LIMIT: r_limit  <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_sel    <= i_motor_select;
            r_period <= i_capture_period;
            r_cmdb   <= i_command_byte;
            r_endb   <= i_end_byte;
        end
        if (i_cmd.num_calc) begin
            r_num <= {14'b0, w_mag} * {16'b0, dmpi_pkg::ERR_SCALE};
            r_neg <= w_diff[SPEED_W];
        end
        if (i_cmd.err_store) begin
            r_err <= r_neg ? $signed(-w_qs) : $signed(w_qs);
        end
        if (i_cmd.prod_p) begin
            r_p1 <= $signed({1'b0, w_kp_m}) * r_err;
        end
        if (i_cmd.prod_i) begin
            r_p2 <= $signed({1'b0, w_ki_m}) * w_sum_m;
        end
        if (i_cmd.out_load) begin
            r_o_pins <= r_pins;
            r_o_d1   <= r_duty_one;
            r_o_d2   <= r_duty_two;
            r_o_wr   <= i_cmd.out_written;
        end
    end

    // speeds, integrators, pins and held duties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_one <= '0;
            r_speed_two <= '0;
            r_sum_one   <= '0;
            r_sum_two   <= '0;
            r_pins      <= '0;
            r_duty_one  <= '0;
            r_duty_two  <= '0;
        end else if (i_cmd.timeout) begin
            r_speed_one <= '0;
            r_speed_two <= '0;
            r_sum_one   <= '0;
            r_sum_two   <= '0;
            r_pins      <= '0;
        end else if (i_cmd.cap_store) begin
            if (r_sel) begin
                r_speed_two <= w_quo[SPEED_W-1:0];
            end else begin
                r_speed_one <= w_quo[SPEED_W-1:0];
            end
        end else if (i_cmd.apply_cmd) begin
            if (w_act.known) begin
                r_pins <= w_act.pins;
            end
            if (w_act.clr_one) begin
                r_sum_one <= '0;
            end
            if (w_act.clr_two) begin
                r_sum_two <= '0;
            end
        end else if (i_cmd.duty_upd) begin
            if (i_cmd.motor) begin
                r_duty_two <= w_duty;
                r_sum_two  <= w_sum_sat;
            end else begin
                r_duty_one <= w_duty;
                r_sum_one  <= w_sum_sat;
            end
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.opcode   = r_op;
        o_stat.frame_ok = (r_endb == dmpi_pkg::FRAME_END);
        o_stat.div_done = w_div_done;
    end

    assign o_direction_pins = r_o_pins;
    assign o_duty_motor_one = r_o_d1;
    assign o_duty_motor_two = r_o_d2;
    assign o_duty_written   = r_o_wr;

endmodule

/* sv/dmpi_ctrl.sv */
// ----------------------------------------------------------------------------
// dmpi_ctrl
// Controller: sequences the datapath through one item, handles the input
// handshake and the result valid flag.
// ----------------------------------------------------------------------------
module dmpi_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  dmpi_pkg::t_dp_stat    i_stat,
    output dmpi_pkg::t_dp_cmd     o_cmd
);
    dmpi_pkg::t_state r_state;
    dmpi_pkg::t_state n_state;
    logic             r_motor;
    logic             n_motor;
    logic             r_written;
    logic             n_written;
    logic             r_out_valid;
    logic             n_out_valid;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmpi_pkg::S_IDLE;
            r_motor     <= 1'b0;
            r_written   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_motor     <= n_motor;
            r_written   <= n_written;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_motor    = r_motor;
        n_written  = r_written;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dmpi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dmpi_pkg::S_DECODE;
                end
            end
            dmpi_pkg::S_DECODE: begin
                n_motor   = 1'b0;
                n_written = 1'b0;
                n_state   = dmpi_pkg::S_OUT;
                case (i_stat.opcode)
                    dmpi_pkg::OP_CAPTURE: begin
                        o_cmd.cap_start = 1'b1;
                        n_state         = dmpi_pkg::S_CAP_WAIT;
                    end
                    dmpi_pkg::OP_FRAME: begin
                        if (i_stat.frame_ok) begin
                            o_cmd.apply_cmd = 1'b1;
                            n_written       = 1'b1;
                            n_state         = dmpi_pkg::S_NUM;
                        end
                    end
                    dmpi_pkg::OP_TIMEOUT: begin
                        o_cmd.timeout = 1'b1;
                    end
                    default: ;
                endcase
            end
            dmpi_pkg::S_CAP_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_store = 1'b1;
                    n_state         = dmpi_pkg::S_OUT;
                end
            end
            dmpi_pkg::S_NUM: begin
                o_cmd.num_calc = 1'b1;
                n_state        = dmpi_pkg::S_ERR_START;
            end
            dmpi_pkg::S_ERR_START: begin
                o_cmd.err_start = 1'b1;
                n_state         = dmpi_pkg::S_ERR_WAIT;
            end
            dmpi_pkg::S_ERR_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.err_store = 1'b1;
                    n_state         = dmpi_pkg::S_PROD_P;
                end
            end
            dmpi_pkg::S_PROD_P: begin
                o_cmd.prod_p = 1'b1;
                n_state      = dmpi_pkg::S_PROD_I;
            end
            dmpi_pkg::S_PROD_I: begin
                o_cmd.prod_i = 1'b1;
                n_state      = dmpi_pkg::S_DUTY;
            end
            dmpi_pkg::S_DUTY: begin
                o_cmd.duty_upd = 1'b1;
                if (!r_motor) begin
                    n_motor = 1'b1;
                    n_state = dmpi_pkg::S_NUM;
                end else begin
                    n_state = dmpi_pkg::S_OUT;
                end
            end
            dmpi_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dmpi_pkg::S_IDLE;
                end
            end
            default: n_state = dmpi_pkg::S_IDLE;
        endcase
        o_cmd.motor       = r_motor;
        o_cmd.out_written = r_written;
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/dual_motor_pi_speed_control.sv */
// Throughput: one item at a time; the next item is taken in the cycle after the
//   result loads. The 30-step divider runs twice per command frame, once per capture.
// Reset: synchronous active-low; registers return to defaults, speeds,
//   integrators, pins and duties clear, no result pending.
// ----------------------------------------------------------------------------
// dual_motor_pi_speed_control
// Two-motor PI speed controller: encoder capture to speed, command frames
// setting direction pins and running one PI step per motor, receive timeout.
// ----------------------------------------------------------------------------
module dual_motor_pi_speed_control #(
    parameter int CAPTURE_BITS = dmpi_pkg::CAPTURE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dmpi_in_if.sink          i_in,
    dmpi_out_if.source       o_out,
    dmpi_cfg_if.sink         i_cfg
);
    dmpi_pkg::t_dp_cmd  w_cmd;
    dmpi_pkg::t_dp_stat w_stat;
    logic               w_in_ready;
    logic               w_out_valid;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    // sequencer
    dmpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // arithmetic and state
    dmpi_dp #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_opcode         (i_in.opcode),
        .i_motor_select   (i_in.motor_select),
        .i_capture_period (i_in.capture_period),
        .i_command_byte   (i_in.command_byte),
        .i_end_byte       (i_in.end_byte),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_direction_pins (o_out.direction_pins),
        .o_duty_motor_one (o_out.duty_motor_one),
        .o_duty_motor_two (o_out.duty_motor_two),
        .o_duty_written   (o_out.duty_written)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule
